### sv/qnw_pkg.sv
// Package for the quaternion normalizer: defaults and the side-band record
// that travels beside the square-root search. No dependencies.
package qnw_pkg;

	localparam int FRAC_BITS_DEF = 15;
	localparam int COMP_W        = 16;
	localparam int WOUT_W        = 32;

	typedef struct packed {
		logic [3:0]              neg;
		logic                    zero;
		logic [3:0][COMP_W-1:0]  mag;
	} qnw_side_t;

endpackage

### sv/qnw_in_if.sv
// Input channel: one quaternion item with valid/ready handshake.
// Uses qnw_pkg for the component width.
interface qnw_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [qnw_pkg::COMP_W-1:0]   in_x;
	logic signed [qnw_pkg::COMP_W-1:0]   in_y;
	logic signed [qnw_pkg::COMP_W-1:0]   in_z;
	logic signed [qnw_pkg::COMP_W-1:0]   in_w;

	modport source (output valid, in_x, in_y, in_z, in_w, input ready);
	modport sink   (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

### sv/qnw_out_if.sv
// Output channel: one normalized quaternion item with flags.
// Uses qnw_pkg for the component widths.
interface qnw_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [qnw_pkg::COMP_W-1:0]   out_x;
	logic signed [qnw_pkg::COMP_W-1:0]   out_y;
	logic signed [qnw_pkg::COMP_W-1:0]   out_z;
	logic signed [qnw_pkg::WOUT_W-1:0]   out_w;
	logic                                zero_length;
	logic                                saturated;

	modport source (output valid, out_x, out_y, out_z, out_w, zero_length, saturated,
		input ready);
	modport sink   (input valid, out_x, out_y, out_z, out_w, zero_length, saturated,
		output ready);
endinterface

### sv/qnw_rsq_lane.sv
// One lane of the scaled reciprocal square root: round(m * 2^F / sqrt(S)),
// one result bit per pipeline stage, shift-and-add only. Uses qnw_pkg.
module qnw_rsq_lane #(
	parameter int FRAC_BITS = qnw_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [30:0]                sq,
	input  logic [31:0]                s,
	output logic [FRAC_BITS+15:0]      r
);
	import qnw_pkg::*;

	localparam int RB = FRAC_BITS + 16;
	localparam int EW = 2 * RB + 40;

	logic signed [EW-1:0] e_s [RB+1];
	logic signed [EW-1:0] p_s [RB+1];
	logic [31:0]          s_s [RB+1];
	logic [RB-1:0]        r_s [RB+1];

	always_ff @(posedge clk) begin
		if (en) begin
			e_s[0] <= ($signed(EW'(sq)) <<< (2 * FRAC_BITS + 2)) - $signed(EW'(s));
			p_s[0] <= -$signed(EW'(s));
			s_s[0] <= s;
			r_s[0] <= '0;
		end
	end

	for (genvar g = 0; g < RB; g++) begin : g_bit
		localparam int K = RB - 1 - g;
		logic signed [EW-1:0] cand;
		assign cand = e_s[g] - (p_s[g] <<< (K + 2)) - ($signed(EW'(s_s[g])) <<< (2 * K + 2));

		always_ff @(posedge clk) begin
			if (en) begin
				s_s[g+1] <= s_s[g];
				if (!cand[EW-1]) begin
					e_s[g+1] <= cand;
					p_s[g+1] <= p_s[g] + ($signed(EW'(s_s[g])) <<< (K + 1));
					r_s[g+1] <= r_s[g] | (RB'(1) << K);
				end else begin
					e_s[g+1] <= e_s[g];
					p_s[g+1] <= p_s[g];
					r_s[g+1] <= r_s[g];
				end
			end
		end
	end

	assign r = r_s[RB];
endmodule

### sv/quaternion_normalize_w_positive.sv
// Top level of the quaternion normalizer with w-positive canonicalization.
// Depends on qnw_pkg, qnw_in_if, qnw_out_if and qnw_rsq_lane.
//
// Usage:
//   in_item  : valid/ready channel carrying in_x, in_y, in_z, in_w (Q1.15).
//   out_item : valid/ready channel carrying out_x, out_y, out_z (Q1.15),
//              out_w (Q17.15), zero_length and saturated.
//   One item may enter every cycle while no waiting result holds the pipeline;
//   throughput is one item per cycle. The reciprocal square root search
//   resolves one result bit per stage over FRAC_BITS + 16 stages, after
//   three front stages (squares, sum, search setup), and is followed by the
//   output register that applies sign, bypass and clamping.
//   Each item leaves exactly once; results are rounded to nearest,
//   ties away from zero, and saturating.
//   Reset clears every valid bit; the pipeline comes up empty.
//   When the receiver holds ready low with a result waiting, the whole
//   pipeline holds and in_item.ready drops; nothing is lost or repeated.
//   Bubbles advance with the pipeline; only a waiting result holds it.
module quaternion_normalize_w_positive #(
	parameter int FRAC_BITS = qnw_pkg::FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	qnw_in_if.sink    in_item,
	qnw_out_if.source out_item
);
	import qnw_pkg::*;

	localparam int RB = FRAC_BITS + 16;
	localparam int LL = RB + 1;
	localparam int MW = (RB > 34) ? RB : 34;

	logic adv;
	logic v_s1, v_s2, out_valid_q;
	logic [LL-1:0] v_l;

	logic signed [COMP_W-1:0] c [4];
	logic [COMP_W-1:0] mag_s1 [4];
	logic [30:0]       sq_s1 [4];
	logic [3:0]        neg_s1;

	logic [31:0]       s_s2;
	logic [30:0]       sq_s2 [4];
	qnw_side_t         side_s2;
	qnw_side_t         side_l [LL];

	logic [RB-1:0]     r_l [4];
	logic [MW-1:0]     fin [4];
	logic [3:0]        satv;
	logic [COMP_W-1:0] o_c [3];
	logic [WOUT_W-1:0] o_w;

	logic signed [COMP_W-1:0] out_x_q, out_y_q, out_z_q;
	logic signed [WOUT_W-1:0] out_w_q;
	logic                     zero_q, sat_q;

	assign adv           = !out_valid_q || out_item.ready;
	assign in_item.ready = adv;

	assign c[0] = in_item.in_x;
	assign c[1] = in_item.in_y;
	assign c[2] = in_item.in_z;
	assign c[3] = in_item.in_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_l         <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= in_item.valid;
			v_s2        <= v_s1;
			v_l         <= {v_l[LL-2:0], v_s2};
			out_valid_q <= v_l[LL-1];
		end
	end

	// Stage 1: magnitudes, squares, output signs.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				mag_s1[i] <= c[i][COMP_W-1] ? COMP_W'(-c[i]) : COMP_W'(c[i]);
				sq_s1[i]  <= 31'(c[i] * c[i]);
				neg_s1[i] <= c[i][COMP_W-1] ^ c[3][COMP_W-1];
			end
		end
	end

	// Stage 2: squared length of the vector part.
	always_ff @(posedge clk) begin
		if (adv) begin
			s_s2 <= 32'(sq_s1[0]) + 32'(sq_s1[1]) + 32'(sq_s1[2]);
			for (int i = 0; i < 4; i++) begin
				sq_s2[i] <= sq_s1[i];
			end
			side_s2.neg  <= neg_s1;
			side_s2.zero <= (sq_s1[0] == '0) && (sq_s1[1] == '0) && (sq_s1[2] == '0);
			for (int i = 0; i < 4; i++) begin
				side_s2.mag[i] <= mag_s1[i];
			end
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_lane
		qnw_rsq_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk (clk),
			.en  (adv),
			.sq  (sq_s2[i]),
			.s   (s_s2),
			.r   (r_l[i])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_l[0] <= side_s2;
			for (int i = 1; i < LL; i++) begin
				side_l[i] <= side_l[i-1];
			end
		end
	end

	// Bypass, cap, sign and clamp.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (side_l[LL-1].zero) begin
				fin[i] = MW'(side_l[LL-1].mag[i]);
			end else if (MW'(r_l[i]) > MW'(64'h8000_0001)) begin
				fin[i] = MW'(64'h8000_0001);
			end else begin
				fin[i] = MW'(r_l[i]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			if (!side_l[LL-1].neg[i] && fin[i] > MW'(32767)) begin
				satv[i] = 1'b1;
				o_c[i]  = 16'h7FFF;
			end else if (side_l[LL-1].neg[i] && fin[i] > MW'(32768)) begin
				satv[i] = 1'b1;
				o_c[i]  = 16'h8000;
			end else begin
				satv[i] = 1'b0;
				o_c[i]  = side_l[LL-1].neg[i] ? -fin[i][15:0] : fin[i][15:0];
			end
		end
		if (!side_l[LL-1].neg[3] && fin[3] > MW'(64'h7FFF_FFFF)) begin
			satv[3] = 1'b1;
			o_w     = 32'h7FFF_FFFF;
		end else if (side_l[LL-1].neg[3] && fin[3] > MW'(64'h8000_0000)) begin
			satv[3] = 1'b1;
			o_w     = 32'h8000_0000;
		end else begin
			satv[3] = 1'b0;
			o_w     = side_l[LL-1].neg[3] ? -fin[3][31:0] : fin[3][31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x_q <= $signed(o_c[0]);
			out_y_q <= $signed(o_c[1]);
			out_z_q <= $signed(o_c[2]);
			out_w_q <= $signed(o_w);
			zero_q  <= side_l[LL-1].zero;
			sat_q   <= |satv;
		end
	end

	assign out_item.valid       = out_valid_q;
	assign out_item.out_x       = out_x_q;
	assign out_item.out_y       = out_y_q;
	assign out_item.out_z       = out_z_q;
	assign out_item.out_w       = out_w_q;
	assign out_item.zero_length = zero_q;
	assign out_item.saturated   = sat_q;
endmodule
